// ===== hdl/ffpa_pkg.sv =====
package ffpa_pkg;

   // bitmap row width and the bit-select width within a row
   localparam int WORD_BITS = 64;
   localparam int SEL_W = 6;

   // field widths
   localparam int CMD_W = 2;
   localparam int IDX_W = 11;
   localparam int STATUS_W = 2;
   localparam int COUNT_W = 12;

   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FREE_REL = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                 found;
      logic [SEL_W-1:0]     pos;
      logic [WORD_BITS-1:0] onehot;
   } zero_hit_type;

endpackage

// ===== hdl/ffpa_find_zero.sv =====
module ffpa_find_zero (
   input  logic [ffpa_pkg::WORD_BITS-1:0] word,
   output ffpa_pkg::zero_hit_type         hit
);
   import ffpa_pkg::*;

   logic [WORD_BITS-1:0] free_bits;
   logic [WORD_BITS-1:0] lowest;

   // lowest zero of word isolated as ~word & (word + 1)
   assign free_bits = ~word;
   assign lowest = free_bits & (word + WORD_BITS'(1));

   always_comb begin
      hit.found = |free_bits;
      hit.onehot = lowest;
      hit.pos = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (lowest[j]) begin
            hit.pos = hit.pos | SEL_W'(j);
         end
      end
   end

endmodule

// ===== hdl/first_free_pool_allocator.sv =====
// First-fit pool allocator over a bitmap of in-use flags.
// Request channel (req_): req_tuser is the command (allocate, release, clear),
// req_tdata carries the entry index used by release. Result channel (rsp_):
// one word per request with the granted index, a status code and the count
// of entries in use after the operation.
// The bitmap sits in a memory of 64-bit rows. One find-first-zero unit is
// reused for every row of an allocate scan; each row visited passes a
// memory read state, then a check state. A next-row hint skips rows known
// full, so an allocate scans from the hint up (1 to ROWS rows). Release
// reads and checks one row; clear, the unused command, an out-of-range
// release and an allocate on a pool known full go straight to the result.
// One request is in work at a time; req_tready is high only while the
// sequencer is idle.
// The result sits in an output register, so a new request is taken while a
// result waits; a finished result then holds until rsp_tready frees it.
// Rows from the fill mark up read as all free, so reset and clear need no
// sweep of the memory.
module first_free_pool_allocator #(
   parameter int POOL_ENTRIES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // entry_index[10:0], zero fill
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // granted_index[10:0], status[12:11],
                                    // used_count[24:13], zero fill
);
   import ffpa_pkg::*;

   localparam int ROWS = (POOL_ENTRIES + WORD_BITS - 1) / WORD_BITS;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int MARK_W = $clog2(ROWS + 1);
   localparam int ENTRY_W = ROW_W + SEL_W;
   localparam int CNT_W = $clog2(POOL_ENTRIES + 1);
   localparam int LAST_BITS = POOL_ENTRIES - (ROWS - 1) * WORD_BITS;
   localparam logic [WORD_BITS-1:0] TAIL_MASK = (LAST_BITS >= WORD_BITS) ? '0 :
      ~((WORD_BITS'(1) << LAST_BITS) - WORD_BITS'(1));
   localparam logic [MARK_W-1:0] LAST_ROW = MARK_W'(ROWS - 1);
   localparam logic [MARK_W-1:0] ALL_ROWS = MARK_W'(ROWS);

   state_type state_ff, state_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [MARK_W-1:0] row_ff, row_in;
   logic [SEL_W-1:0] bit_ff, bit_in;
   logic [MARK_W-1:0] hint_ff, hint_in;
   logic [MARK_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ENTRY_W-1:0] res_idx_ff, res_idx_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic [WORD_BITS-1:0] map_mem [ROWS];
   logic [WORD_BITS-1:0] map_q;
   logic map_we;
   logic [WORD_BITS-1:0] map_wdata;

   logic [WORD_BITS-1:0] row_word;
   zero_hit_type hit;
   logic [IDX_W-1:0] req_idx;
   logic idx_in_range;

   assign req_idx = req_tdata[IDX_W-1:0];
   assign idx_in_range = (32'(req_idx) < 32'(POOL_ENTRIES));

   // rows at or above the fill mark were never written since clear; tail bits act used
   assign row_word = ((row_ff < fill_ff) ? map_q : '0) |
                     ((row_ff == LAST_ROW) ? TAIL_MASK : '0);

   ffpa_find_zero u_find_zero (
      .word (row_word),
      .hit  (hit)
   );

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[row_ff[ROW_W-1:0]] <= map_wdata;
      end
      map_q <= map_mem[row_ff[ROW_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hint_ff <= '0;
         fill_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hint_ff <= hint_in;
         fill_ff <= fill_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      row_ff <= row_in;
      bit_ff <= bit_in;
      res_idx_ff <= res_idx_in;
      res_status_ff <= res_status_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      row_in = row_ff;
      bit_in = bit_ff;
      hint_in = hint_ff;
      fill_in = fill_ff;
      count_in = count_ff;
      res_idx_in = res_idx_ff;
      res_status_in = res_status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff;
      map_we = 1'b0;
      map_wdata = row_word;
      req_tready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in = req_tuser;
               res_idx_in = '0;
               res_status_in = STATUS_OK;
               state_in = ST_DONE;
               case (req_tuser)
                  CMD_ALLOC: begin
                     if (hint_ff == ALL_ROWS) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        row_in = hint_ff;
                        state_in = ST_READ;
                     end
                  end
                  CMD_RELEASE: begin
                     if (idx_in_range) begin
                        row_in = MARK_W'(req_idx >> SEL_W);
                        bit_in = req_idx[SEL_W-1:0];
                        state_in = ST_READ;
                     end else begin
                        res_status_in = STATUS_FREE_REL;
                     end
                  end
                  CMD_CLEAR: begin
                     hint_in = '0;
                     fill_in = '0;
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (cmd_ff == CMD_ALLOC) begin
               if (hit.found) begin
                  map_we = 1'b1;
                  map_wdata = row_word | hit.onehot;
                  if (row_ff == fill_ff) begin
                     fill_in = fill_ff + MARK_W'(1);
                  end
                  hint_in = row_ff;
                  count_in = count_ff + CNT_W'(1);
                  res_idx_in = {row_ff[ROW_W-1:0], hit.pos};
                  state_in = ST_DONE;
               end else if (row_ff == LAST_ROW) begin
                  // every row full: later allocates answer at once
                  hint_in = ALL_ROWS;
                  res_status_in = STATUS_FULL;
                  state_in = ST_DONE;
               end else begin
                  row_in = row_ff + MARK_W'(1);
                  state_in = ST_READ;
               end
            end else begin
               if (row_word[bit_ff]) begin
                  map_we = 1'b1;
                  map_wdata = row_word & ~(WORD_BITS'(1) << bit_ff);
                  count_in = count_ff - CNT_W'(1);
                  if (row_ff < hint_ff) begin
                     hint_in = row_ff;
                  end
               end else begin
                  res_status_in = STATUS_FREE_REL;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {7'd0, COUNT_W'(count_ff), res_status_ff,
                              IDX_W'(res_idx_ff)};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(POOL_ENTRIES))
      else $error("in-use count above pool size");

   a_hint_below_fill: assert property (@(posedge clock) disable iff (reset)
      hint_ff <= fill_ff)
      else $error("scan hint above fill mark");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in work");

   a_write_in_check: assert property (@(posedge clock) disable iff (reset)
      map_we |-> (state_ff == ST_CHECK) && (row_ff <= fill_ff))
      else $error("bitmap write outside check or above fill mark");
`endif

endmodule

// ===== verif/first_free_pool_allocator_test.sv =====
`timescale 1ns / 100ps

module first_free_pool_allocator_test;
   import ffpa_pkg::*;

   localparam int POOL_ENTRIES = 2048;
   localparam int RANDOM_ITEMS = 1350;
   localparam int CYCLE_LIMIT = 2_500_000;
   localparam int DRAIN_CYCLES = 120;
   localparam int REPORT_LINES = 40;
   // unused command code, taken as no operation
   localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

   typedef struct {
      logic [CMD_W-1:0] op;
      logic [IDX_W-1:0] index;
      bit               wait_idle;
   } pool_request_type;

   typedef struct packed {
      logic [IDX_W-1:0]    granted;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } pool_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // entry_index[10:0], zero fill
   logic [1:0]  req_tuser = '0;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // granted_index[10:0], status[12:11],
                                  // used_count[24:13], zero fill

   pool_request_type pending_requests[$];
   pool_result_type  expected_results[$];

   // predicted pool state
   bit [POOL_ENTRIES-1:0] pool_in_use = '0;
   logic [COUNT_W-1:0]    pool_count = '0;

   // rough count of entries in use, only to steer releases toward used entries
   int gen_level = 0;

   int mismatch_count = 0;
   int cycle_count = 0;
   int send_gap = 0;
   int send_quiet = 0;
   bit send_hold;
   int recv_stall = 0;
   int recv_quiet = 0;
   pool_result_type seen_word;
   pool_result_type want_word;

   first_free_pool_allocator #(
      .POOL_ENTRIES(POOL_ENTRIES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < REPORT_LINES) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
      mismatch_count++;
   endtask

   function automatic int draw_idle(input int quiet_left);
      int r;
      if (quiet_left > 0) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // applies a command to the predicted map (first-fit allocation), pushes the expected word
   task automatic apply_pool_op(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] index);
      pool_result_type r;
      int slot;
      r = '0;
      r.status = STATUS_OK;
      case (op)
         CMD_ALLOC: begin
            slot = -1;
            for (int i = 0; i < POOL_ENTRIES && slot < 0; i++) begin
               if (!pool_in_use[i]) slot = i;
            end
            if (slot < 0) begin
               r.status = STATUS_FULL;
            end else begin
               pool_in_use[slot] = 1'b1;
               pool_count++;
               r.granted = slot[IDX_W-1:0];
            end
         end
         CMD_RELEASE: begin
            if (int'(index) < POOL_ENTRIES && pool_in_use[index]) begin
               pool_in_use[index] = 1'b0;
               if (pool_count > 0) pool_count--;
            end else begin
               r.status = STATUS_FREE_REL;
            end
         end
         CMD_CLEAR: begin
            pool_in_use = '0;
            pool_count = '0;
         end
         default: ;
      endcase
      r.count = pool_count;
      expected_results.push_back(r);
   endtask

   task automatic queue_request(input logic [CMD_W-1:0] op, input int index,
                                input bit wait_idle);
      pool_request_type q;
      q.op = op;
      q.index = index[IDX_W-1:0];
      q.wait_idle = wait_idle;
      pending_requests.push_back(q);
      case (op)
         CMD_ALLOC:   if (gen_level < POOL_ENTRIES) gen_level++;
         CMD_RELEASE: if (index < gen_level && gen_level > 0) gen_level--;
         CMD_CLEAR:   gen_level = 0;
         default: ;
      endcase
   endtask

   function automatic int release_pick();
      int hi;
      hi = gen_level + 2;
      if (hi > POOL_ENTRIES - 1) hi = POOL_ENTRIES - 1;
      return $urandom_range(0, hi);
   endfunction

   // request side: holds a word until taken, then idles a random while
   always @(posedge clock) begin : request_driver
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= '0;
      end else begin
         send_hold = req_tvalid && !req_tready;
         if (req_tvalid && req_tready) begin
            apply_pool_op(req_tuser, req_tdata[IDX_W-1:0]);
            if (send_quiet > 0) send_quiet--;
            else if ($urandom_range(0, 29) == 0) send_quiet = $urandom_range(20, 80);
            send_gap = draw_idle(send_quiet);
         end
         if (!send_hold) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0 &&
                         !(pending_requests[0].wait_idle && expected_results.size() > 0)) begin
               req_tvalid <= 1'b1;
               req_tuser <= pending_requests[0].op;
               req_tdata <= {{(16 - IDX_W){1'b0}}, pending_requests[0].index};
               void'(pending_requests.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result side: checks each word against the oldest prediction
   always @(posedge clock) begin : result_monitor
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_word.granted = rsp_tdata[10:0];
            seen_word.status = rsp_tdata[12:11];
            seen_word.count = rsp_tdata[24:13];
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result word 0x%08h with nothing expected", rsp_tdata));
            end else begin
               want_word = expected_results.pop_front();
               if (seen_word.granted !== want_word.granted)
                  report_mismatch($sformatf("granted_index %0d, expected %0d",
                                            seen_word.granted, want_word.granted));
               if (seen_word.status !== want_word.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            seen_word.status, want_word.status));
               if (seen_word.count !== want_word.count)
                  report_mismatch($sformatf("used_count %0d, expected %0d",
                                            seen_word.count, want_word.count));
            end
            if (recv_quiet > 0) recv_quiet--;
            else if ($urandom_range(0, 29) == 0) recv_quiet = $urandom_range(20, 80);
            recv_stall = draw_idle(recv_quiet);
         end else if (!rsp_tvalid && recv_stall == 0 && recv_quiet == 0 &&
                      $urandom_range(0, 15) == 0) begin
            // stall spells that start while the block is still working
            recv_stall = $urandom_range(1, 6);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      int random_count;
      int kind;
      int seg_len;
      int r;
      bit first_wait;
      bit filled;

      // directed: first fit, reuse of the lowest entry, free releases, clear, nop
      queue_request(CMD_ALLOC, 2047, 1'b0);
      queue_request(CMD_ALLOC, 0, 1'b0);
      queue_request(CMD_RELEASE, 2047, 1'b0);
      queue_request(CMD_RELEASE, 0, 1'b0);
      queue_request(CMD_RELEASE, 0, 1'b0);
      queue_request(CMD_ALLOC, 1365, 1'b0);
      queue_request(CMD_ALLOC, 682, 1'b0);
      queue_request(CMD_RELEASE, 1, 1'b0);
      queue_request(CMD_ALLOC, 0, 1'b0);
      queue_request(CMD_NOP, 2047, 1'b0);
      queue_request(CMD_NOP, 0, 1'b0);
      queue_request(CMD_RELEASE, 1365, 1'b0);
      queue_request(CMD_RELEASE, 682, 1'b0);
      queue_request(CMD_CLEAR, 2047, 1'b0);
      queue_request(CMD_RELEASE, 2, 1'b0);
      queue_request(CMD_ALLOC, 0, 1'b0);
      queue_request(CMD_CLEAR, 0, 1'b0);
      queue_request(CMD_CLEAR, 1024, 1'b0);

      random_count = 0;
      filled = 1'b0;
      while (random_count < RANDOM_ITEMS) begin
         if (!filled && random_count > RANDOM_ITEMS / 3) begin
            // fill the whole pool: full reports, top entry, count at its maximum
            queue_request(CMD_CLEAR, $urandom_range(0, 2047), 1'b1);
            for (int i = 0; i < POOL_ENTRIES; i++) begin
               queue_request(CMD_ALLOC, $urandom_range(0, 2047), 1'b0);
               if ($urandom_range(0, 149) == 0) begin
                  queue_request(CMD_RELEASE, release_pick(), 1'b0);
                  queue_request(CMD_ALLOC, $urandom_range(0, 2047), 1'b0);
               end
            end
            for (int i = 0; i < 4; i++) queue_request(CMD_ALLOC, $urandom_range(0, 2047), 1'b0);
            queue_request(CMD_RELEASE, 2047, 1'b0);
            queue_request(CMD_ALLOC, 0, 1'b0);
            queue_request(CMD_ALLOC, 0, 1'b0);
            queue_request(CMD_NOP, 1023, 1'b0);
            queue_request(CMD_RELEASE, $urandom_range(1024, 2047), 1'b0);
            queue_request(CMD_RELEASE, $urandom_range(0, 1023), 1'b0);
            queue_request(CMD_ALLOC, 0, 1'b0);
            queue_request(CMD_ALLOC, 0, 1'b0);
            filled = 1'b1;
         end
         kind = $urandom_range(0, 9);
         first_wait = ($urandom_range(0, 5) == 0);
         case (kind)
            0, 1, 2, 3, 4, 5: begin
               // churn: allocate and release mostly live entries
               seg_len = $urandom_range(10, 40);
               for (int i = 0; i < seg_len; i++) begin
                  r = $urandom_range(0, 99);
                  if (r < 55)
                     queue_request(CMD_ALLOC, $urandom_range(0, 2047), first_wait && i == 0);
                  else if (r < 90)
                     queue_request(CMD_RELEASE, release_pick(), first_wait && i == 0);
                  else if (r < 96)
                     queue_request(CMD_RELEASE, $urandom_range(0, 2047), first_wait && i == 0);
                  else
                     queue_request(CMD_NOP, $urandom_range(0, 2047), first_wait && i == 0);
               end
               random_count += seg_len;
            end
            6: begin
               seg_len = $urandom_range(2, 8);
               queue_request(CMD_CLEAR, $urandom_range(0, 2047), first_wait);
               for (int i = 0; i < seg_len; i++)
                  queue_request(CMD_ALLOC, $urandom_range(0, 2047), 1'b0);
               random_count += seg_len + 1;
            end
            7: begin
               // noise: any command, any index
               seg_len = $urandom_range(5, 15);
               for (int i = 0; i < seg_len; i++)
                  queue_request(CMD_W'($urandom_range(0, 3)), $urandom_range(0, 2047),
                                first_wait && i == 0);
               random_count += seg_len;
            end
            default: begin
               seg_len = $urandom_range(20, 80);
               for (int i = 0; i < seg_len; i++)
                  queue_request(CMD_ALLOC, $urandom_range(0, 2047), first_wait && i == 0);
               random_count += seg_len;
            end
         endcase
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
